[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/bba_pkg.sv]
// package with shared constants and payload types of the buddy allocator
`default_nettype none

package bba_pkg;

  localparam int MIN_BLOCK_LOG2_DEF = 10;
  localparam int NUM_ORDERS_DEF     = 11;
  localparam int NUM_MIN_BLOCKS_DEF = 4096;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 24;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 23;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_REGION_BASE = 1'b0;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd4;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] size_bytes;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [COUNT_W-1:0]  free_bytes;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/bba_if.sv]
// valid/ready channel interfaces for requests and results
`default_nettype none

interface bba_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [bba_pkg::ADDR_W-1:0] block_address;
  logic [bba_pkg::SIZE_W-1:0] size_bytes;
  modport source (output valid, action, block_address, size_bytes, input ready);
  modport sink   (input valid, action, block_address, size_bytes, output ready);
endinterface

interface bba_out_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::ADDR_W-1:0]   granted_address;
  logic [bba_pkg::COUNT_W-1:0]  free_bytes;
  modport source (output valid, status, granted_address, free_bytes, input ready);
  modport sink   (input valid, status, granted_address, free_bytes, output ready);
endinterface

`default_nettype wire

[hdl/bba_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module bba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/bba_seq.sv]
// sequencer that walks the free lists and block tables one step per cycle, holding in S_DONE while the output is full
`default_nettype none

module bba_seq #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int NUM_ORDERS     = bba_pkg::NUM_ORDERS_DEF,
  parameter int NUM_MIN_BLOCKS = bba_pkg::NUM_MIN_BLOCKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bba_pkg::ADDR_W-1:0] region_base,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire bba_pkg::req_t              req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bba_pkg::rsp_t                   rsp
);

  localparam int IXW  = $clog2(NUM_MIN_BLOCKS);
  localparam int LW   = $clog2(NUM_MIN_BLOCKS + 1);
  localparam int KW   = $clog2(NUM_ORDERS + 1);
  localparam int HW   = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int TOP  = MIN_BLOCK_LOG2 + NUM_ORDERS - 1;
  localparam int VW   = MIN_BLOCK_LOG2 + NUM_ORDERS;
  localparam int SUMW = ((VW > bba_pkg::COUNT_W) ? VW : bba_pkg::COUNT_W) + 1;
  localparam int CMPW = ((bba_pkg::SIZE_W > VW) ? bba_pkg::SIZE_W : VW) + 1;
  localparam int MW   = ((IXW > NUM_ORDERS) ? IXW : NUM_ORDERS) + 1;
  localparam int AW   = bba_pkg::ADDR_W;

  localparam logic [LW-1:0]  EMPTY = LW'(NUM_MIN_BLOCKS);
  localparam logic [KW-1:0]  K_TOP = KW'(NUM_ORDERS);
  localparam logic [IXW-1:0] CLR_LAST = IXW'(NUM_MIN_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROUND, S_DISP, S_ASCAN, S_AUNL_RD, S_AUNL_WR, S_SPLIT,
    S_FCHK_RD, S_FCHK, S_MRG_RD, S_MRG_CHK, S_PUSH_A, S_PUSH_B, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     act_r, act_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [bba_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [KW-1:0]            k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, pord_r, pord_nxt;
  logic [IXW-1:0]           idx_r, idx_nxt, par_r, par_nxt, pidx_r, pidx_nxt;
  logic [IXW-1:0]           clr_r, clr_nxt;
  logic [LW-1:0]            h_r, h_nxt;
  logic [bba_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [AW-1:0]            grant_r, grant_nxt;
  logic [bba_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0]            head_r [NUM_ORDERS];
  logic [LW-1:0]            head_nxt [NUM_ORDERS];
  logic                     out_valid_r, out_valid_nxt;
  bba_pkg::rsp_t            rsp_r, rsp_nxt;

  logic [IXW-1:0] rd_addr;
  logic           fsb_we, fsb_wd, fsb_rd;
  logic [IXW-1:0] fsb_wa;
  logic           ord_we;
  logic [IXW-1:0] ord_wa;
  logic [KW-1:0]  ord_wd, ord_rd;
  logic           nxt_we, prv_we;
  logic [IXW-1:0] nxt_wa, prv_wa;
  logic [LW-1:0]  nxt_wd, prv_wd, nxt_rd, prv_rd;

  logic [AW-1:0]   base_w, off_w;
  logic [SUMW-1:0] blk_bytes, cnt_sum;
  logic [MW-1:0]   s_w, par_w, bud_w;

  bba_ram #(.W(1),  .D(NUM_MIN_BLOCKS)) u_fsb (
    .clk(clk), .we(fsb_we), .waddr(fsb_wa), .wdata(fsb_wd), .raddr(rd_addr), .rdata(fsb_rd));
  bba_ram #(.W(KW), .D(NUM_MIN_BLOCKS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(rd_addr), .rdata(ord_rd));
  bba_ram #(.W(LW), .D(NUM_MIN_BLOCKS)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(rd_addr), .rdata(nxt_rd));
  bba_ram #(.W(LW), .D(NUM_MIN_BLOCKS)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(rd_addr), .rdata(prv_rd));

  assign base_w    = region_base & ~((AW'(1) << TOP) - AW'(1));
  assign off_w     = addr_r - base_w;
  assign blk_bytes = SUMW'(1) << (MIN_BLOCK_LOG2 + int'(k_r));
  assign cnt_sum   = SUMW'(cnt_r) + blk_bytes;
  assign s_w       = MW'(1) << k_r;
  assign par_w     = MW'(idx_r) & ~((s_w << 1) - MW'(1));
  assign bud_w     = (par_w == MW'(idx_r)) ? MW'(idx_r) + s_w : par_w;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign rsp       = rsp_r;

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    addr_nxt   = addr_r;
    size_nxt   = size_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pord_nxt   = pord_r;
    idx_nxt    = idx_r;
    par_nxt    = par_r;
    pidx_nxt   = pidx_r;
    clr_nxt    = clr_r;
    h_nxt      = h_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    out_valid_nxt = out_valid_r;
    rsp_nxt    = rsp_r;
    rd_addr = idx_r;
    fsb_we = 1'b0; fsb_wa = idx_r; fsb_wd = 1'b0;
    ord_we = 1'b0; ord_wa = pidx_r; ord_wd = pord_r;
    nxt_we = 1'b0; nxt_wa = pidx_r; nxt_wd = nxt_rd;
    prv_we = 1'b0; prv_wa = pidx_r; prv_wd = prv_rd;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        fsb_we  = 1'b1;
        fsb_wa  = clr_r;
        clr_nxt = clr_r + IXW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = req.action;
          addr_nxt   = req.block_address;
          size_nxt   = req.size_bytes;
          k_nxt      = '0;
          status_nxt = bba_pkg::ST_OK;
          grant_nxt  = '0;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        if (k_r < K_TOP &&
            (CMPW'(1) << (MIN_BLOCK_LOG2 + int'(k_r))) < CMPW'(size_r)) begin
          k_nxt = k_r + KW'(1);
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (act_r == bba_pkg::ACT_ALLOC) begin
          if (k_r >= K_TOP) begin
            status_nxt = bba_pkg::ST_TOO_LARGE;
            state_nxt  = S_DONE;
          end else begin
            i_nxt     = k_r;
            state_nxt = S_ASCAN;
          end
        end else if (addr_r < base_w ||
                     (off_w >> MIN_BLOCK_LOG2) >= AW'(NUM_MIN_BLOCKS)) begin
          status_nxt = bba_pkg::ST_BAD_ADDR;
          state_nxt  = S_DONE;
        end else if (k_r >= K_TOP) begin
          status_nxt = bba_pkg::ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = off_w[MIN_BLOCK_LOG2 +: IXW];
          state_nxt = S_FCHK_RD;
        end
      end
      S_ASCAN: begin
        if (i_r >= K_TOP) begin
          status_nxt = bba_pkg::ST_NO_FREE;
          state_nxt  = S_DONE;
        end else if (head_r[i_r[HW-1:0]] == EMPTY) begin
          i_nxt = i_r + KW'(1);
        end else begin
          idx_nxt   = head_r[i_r[HW-1:0]][IXW-1:0];
          state_nxt = S_AUNL_RD;
        end
      end
      S_AUNL_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_AUNL_WR;
      end
      S_AUNL_WR, S_MRG_CHK: begin
        if (state_r == S_MRG_CHK && (!fsb_rd || ord_rd != k_r)) begin
          pidx_nxt  = idx_r;
          pord_nxt  = k_r;
          state_nxt = S_PUSH_A;
        end else begin
          if (prv_rd < EMPTY) begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd[IXW-1:0];
            nxt_wd = nxt_rd;
          end else if (ord_rd < K_TOP) begin
            head_nxt[ord_rd[HW-1:0]] = nxt_rd;
          end
          if (nxt_rd < EMPTY) begin
            prv_we = 1'b1;
            prv_wa = nxt_rd[IXW-1:0];
            prv_wd = prv_rd;
          end
          fsb_we = 1'b1;
          fsb_wd = 1'b0;
          if (state_r == S_MRG_CHK) begin
            fsb_wa    = bud_w[IXW-1:0];
            idx_nxt   = par_r;
            k_nxt     = k_r + KW'(1);
            state_nxt = S_MRG_RD;
          end else begin
            fsb_wa    = idx_r;
            j_nxt     = k_r;
            state_nxt = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (j_r < i_r) begin
          pidx_nxt  = IXW'(MW'(idx_r) + (MW'(1) << j_r));
          pord_nxt  = j_r;
          state_nxt = S_PUSH_A;
        end else begin
          cnt_nxt   = (SUMW'(cnt_r) >= blk_bytes) ?
                      bba_pkg::COUNT_W'(SUMW'(cnt_r) - blk_bytes) : '0;
          grant_nxt = base_w + (AW'(idx_r) << MIN_BLOCK_LOG2);
          state_nxt = S_DONE;
        end
      end
      S_FCHK_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (fsb_rd) begin
          status_nxt = bba_pkg::ST_DBL_FREE;
          state_nxt  = S_DONE;
        end else if (MW'(idx_r) + s_w > MW'(NUM_MIN_BLOCKS)) begin
          status_nxt = bba_pkg::ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt   = (cnt_sum > SUMW'(bba_pkg::COUNT_MAX)) ?
                      bba_pkg::COUNT_MAX : bba_pkg::COUNT_W'(cnt_sum);
          state_nxt = S_MRG_RD;
        end
      end
      S_MRG_RD: begin
        if (int'(k_r) + 1 >= NUM_ORDERS || bud_w >= MW'(NUM_MIN_BLOCKS)) begin
          pidx_nxt  = idx_r;
          pord_nxt  = k_r;
          state_nxt = S_PUSH_A;
        end else begin
          rd_addr   = bud_w[IXW-1:0];
          par_nxt   = par_w[IXW-1:0];
          state_nxt = S_MRG_CHK;
        end
      end
      S_PUSH_A: begin
        h_nxt  = head_r[pord_r[HW-1:0]];
        nxt_we = 1'b1;
        nxt_wa = pidx_r;
        nxt_wd = head_r[pord_r[HW-1:0]];
        prv_we = 1'b1;
        prv_wa = pidx_r;
        prv_wd = EMPTY;
        ord_we = 1'b1;
        fsb_we = 1'b1;
        fsb_wa = pidx_r;
        fsb_wd = 1'b1;
        head_nxt[pord_r[HW-1:0]] = LW'(pidx_r);
        state_nxt = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (h_r < EMPTY) begin
          prv_we = 1'b1;
          prv_wa = h_r[IXW-1:0];
          prv_wd = LW'(pidx_r);
        end
        if (act_r == bba_pkg::ACT_ALLOC) begin
          j_nxt     = j_r + KW'(1);
          state_nxt = S_SPLIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          rsp_nxt.status          = status_r;
          rsp_nxt.granted_address = grant_r;
          rsp_nxt.free_bytes      = cnt_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < NUM_ORDERS; n++) begin
        head_r[n] <= EMPTY;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
    act_r    <= act_nxt;
    addr_r   <= addr_nxt;
    size_r   <= size_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pord_r   <= pord_nxt;
    idx_r    <= idx_nxt;
    par_r    <= par_nxt;
    pidx_r   <= pidx_nxt;
    h_r      <= h_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    rsp_r    <= rsp_nxt;
  end

endmodule

`default_nettype wire

[hdl/buddy_block_allocator_unit.sv]
// top level of the buddy block allocator with its configuration port
//
// in_chan carries allocate and free requests, out_chan one result per request
// (status, granted address, free byte count). both use valid/ready; a transfer
// happens at a clock edge with valid and ready high.
// one request at a time: in_chan.ready is high only while the unit is idle.
// a request takes the size rounding walk, then on allocate a scan of the list
// heads, an unlink (read, then write) and, per split-off half, a split step
// and the link steps S_PUSH_A and S_PUSH_B; on free a read and a check step,
// a read and a check step per merge and a link through both push steps.
// all steps share the one read port of the block tables; the result is
// registered as the unit goes back to idle.
// the result sits in an output register; the next request is taken while it
// waits, and a stalled out_chan holds the second result until the first goes.
// after reset the unit clears its free-start table, one entry per cycle, with
// in_chan.ready low until all NUM_MIN_BLOCKS entries are clear; region_base may
// be written over the cfg_ port at any time the unit is idle.
`default_nettype none

module buddy_block_allocator_unit #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int NUM_ORDERS     = bba_pkg::NUM_ORDERS_DEF,
  parameter int NUM_MIN_BLOCKS = bba_pkg::NUM_MIN_BLOCKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bba_in_if.sink                          in_chan,
  bba_out_if.source                       out_chan,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bba_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [bba_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [bba_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic [bba_pkg::ADDR_W-1:0] base_r;
  bba_pkg::req_t              req;
  bba_pkg::rsp_t              rsp;
  logic                       cfg_sel_base;

  assign cfg_sel_base = (cfg_paddr[bba_pkg::CFG_AW-1] == bba_pkg::REG_REGION_BASE);
  assign cfg_pready   = 1'b1;
  assign cfg_prdata   = cfg_sel_base ? bba_pkg::CFG_DW'(base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_base) begin
      base_r <= cfg_pwdata[bba_pkg::ADDR_W-1:0];
    end
  end

  assign req.action        = in_chan.action;
  assign req.block_address = in_chan.block_address;
  assign req.size_bytes    = in_chan.size_bytes;

  bba_seq #(
    .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
    .NUM_ORDERS    (NUM_ORDERS),
    .NUM_MIN_BLOCKS(NUM_MIN_BLOCKS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .region_base(base_r),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .req        (req),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .rsp        (rsp)
  );

  assign out_chan.status          = rsp.status;
  assign out_chan.granted_address = rsp.granted_address;
  assign out_chan.free_bytes      = rsp.free_bytes;

endmodule

`default_nettype wire

[hdl/bba_checker.sv]
// port-level checker for the buddy allocator and its bind
`default_nettype none
`include "assert_macros.svh"

module bba_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [bba_pkg::STATUS_W-1:0] out_status,
  input wire logic [bba_pkg::ADDR_W-1:0]   out_granted,
  input wire logic [bba_pkg::COUNT_W-1:0]  out_free
);

  logic [bba_pkg::STATUS_W+bba_pkg::ADDR_W+bba_pkg::COUNT_W-1:0] out_pay;

  assign out_pay = {out_status, out_granted, out_free};

  `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay))
  `BBA_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `BBA_ASSERT_IMP(a_err_no_grant, out_valid && out_status != bba_pkg::ST_OK, out_granted == '0)
  `BBA_ASSERT_IMP(a_status_known, out_valid, out_status <= bba_pkg::ST_DBL_FREE)

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_granted(out_chan.granted_address),
  .out_free   (out_chan.free_bytes)
);

`default_nettype wire
